FILE: hw/rtl/mme_pkg.sv
// Shared types, constants and the rounding helper of the matrix multiply engine.
// Used by mme_cell and matrix_multiply_engine; depends on nothing else.
package mme_pkg;

   localparam int MAX_DIM   = 8;
   localparam int DIM_W     = $clog2(MAX_DIM);
   localparam int DATA_W    = 32;
   localparam int FRAC_W    = 16;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int ACC_W     = PROD_W + DIM_W;
   localparam int LEFT_N    = MAX_DIM * MAX_DIM;
   localparam int DRAIN_CYC = MAX_DIM + 4;
   localparam int DRAIN_W   = $clog2(DRAIN_CYC);

   localparam logic [1:0] KIND_LEFT    = 2'd0;
   localparam logic [1:0] KIND_RIGHT   = 2'd1;
   localparam logic [1:0] KIND_COMPUTE = 2'd2;
   localparam logic [1:0] KIND_UNUSED  = 2'd3;

   localparam logic [1:0] REG_LEFT_ROWS  = 2'd0;
   localparam logic [1:0] REG_LEFT_COLS  = 2'd1;
   localparam logic [1:0] REG_RIGHT_ROWS = 2'd2;
   localparam logic [1:0] REG_RIGHT_COLS = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_EMIT,
      ST_ERROR
   } state_type;

   typedef struct packed {
      logic [1:0]               kind;
      logic [2:0]               row_index;
      logic [2:0]               col_index;
      logic signed [DATA_W-1:0] element_value;
   } req_type;

   typedef struct packed {
      logic [2:0]               out_row;
      logic [2:0]               out_col;
      logic signed [DATA_W-1:0] out_value;
      logic                     status;
      logic                     last;
   } rsp_type;

   // one left element traveling down the chain of cells
   typedef struct packed {
      logic                     vld;
      logic                     first;
      logic                     last;
      logic [DIM_W-1:0]         k;
      logic signed [DATA_W-1:0] a;
   } token_type;

   // write of one right element into the column cell
   typedef struct packed {
      logic                     en;
      logic [DIM_W-1:0]         row;
      logic signed [DATA_W-1:0] value;
   } bwr_type;

   // round the Q35.32 sum half up to Q16.16 and saturate to the data width
   function automatic logic signed [DATA_W-1:0] sat_round(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] rnd;
      logic signed [ACC_W-1:0] sh;
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      rnd = acc + ACC_W'(1 << (FRAC_W - 1));
      sh  = rnd >>> FRAC_W;
      hi  = ACC_W'({1'b0, {(DATA_W-1){1'b1}}});
      lo  = -hi - ACC_W'(1);
      if (sh > hi) begin
         return {1'b0, {(DATA_W-1){1'b1}}};
      end else if (sh < lo) begin
         return {1'b1, {(DATA_W-1){1'b0}}};
      end
      return sh[DATA_W-1:0];
   endfunction

endpackage

FILE: hw/rtl/matrix_multiply_engine.sv
// Top level of the matrix multiply engine: register port, left store, sequencer,
// chain of mme_cell column cells and result register. Uses mme_pkg and mme_cell.
//
// Usage:
//   Requests enter on req_valid/req_ready with a req_type payload. Kind 0 loads a
//   left element, kind 1 a right element, kind 2 starts a product. Loads are
//   accepted back to back while the engine is idle.
//   A product streams results on rsp_valid/rsp_ready in row-major order, last
//   marked; a dimension mismatch or a zero dimension gives one result with status set.
//   Per product row the sequencer feeds inner-count left elements down the chain
//   of MAX_DIM cells, waits in the drain state for the last cell to finish, then
//   emits one result per cycle while the receiver accepts. No new request is
//   taken while a product runs. A stalled receiver holds the result register
//   and the sequencer waits. Reset clears the stores to zero (per-entry valid
//   bits) and the dimension registers to 8. Dimension registers are written
//   over the APB port at byte addresses 0, 4, 8, 12; the user must write them
//   only while idle, as the block itself does not enforce it.
module matrix_multiply_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mme_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mme_pkg::rsp_type  rsp_payload,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import mme_pkg::*;

   logic [3:0] left_rows_ff, left_cols_ff, right_rows_ff, right_cols_ff;
   logic [3:0] lr, lc, rr, rc;
   logic       dim_err;

   state_type  state_ff, state_in;
   logic [DIM_W-1:0]   i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [DRAIN_W-1:0] cnt_ff, cnt_in;
   logic       issue, emit_ok, err_ld, lwr, rwr, out_free;

   logic signed [DATA_W-1:0] left_mem [LEFT_N];
   logic [LEFT_N-1:0]        left_vld_ff;
   logic [2*DIM_W-1:0]       rd_addr;

   token_type                tok_c [MAX_DIM+1];
   logic signed [DATA_W-1:0] res_c [MAX_DIM];

   rsp_type rsp_ff;
   logic    rsp_valid_ff;

   // register port
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_rows_ff  <= 4'd8;
         left_cols_ff  <= 4'd8;
         right_rows_ff <= 4'd8;
         right_cols_ff <= 4'd8;
      end else if (psel && penable && pwrite) begin
         unique case (paddr[3:2])
            REG_LEFT_ROWS:  left_rows_ff  <= pwdata[3:0];
            REG_LEFT_COLS:  left_cols_ff  <= pwdata[3:0];
            REG_RIGHT_ROWS: right_rows_ff <= pwdata[3:0];
            REG_RIGHT_COLS: right_cols_ff <= pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_LEFT_ROWS:  prdata = {28'd0, left_rows_ff};
         REG_LEFT_COLS:  prdata = {28'd0, left_cols_ff};
         REG_RIGHT_ROWS: prdata = {28'd0, right_rows_ff};
         REG_RIGHT_COLS: prdata = {28'd0, right_cols_ff};
         default:        prdata = '0;
      endcase
   end

   // clamp dimensions to the array size
   assign lr = (left_rows_ff  > 4'(MAX_DIM)) ? 4'(MAX_DIM) : left_rows_ff;
   assign lc = (left_cols_ff  > 4'(MAX_DIM)) ? 4'(MAX_DIM) : left_cols_ff;
   assign rr = (right_rows_ff > 4'(MAX_DIM)) ? 4'(MAX_DIM) : right_rows_ff;
   assign rc = (right_cols_ff > 4'(MAX_DIM)) ? 4'(MAX_DIM) : right_cols_ff;
   assign dim_err = (lc != rr) || (lr == 4'd0) || (lc == 4'd0) ||
                    (rr == 4'd0) || (rc == 4'd0);

   assign out_free = !rsp_valid_ff || rsp_ready;

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      cnt_in    = cnt_ff;
      req_ready = 1'b0;
      issue     = 1'b0;
      emit_ok   = 1'b0;
      err_ld    = 1'b0;
      lwr       = 1'b0;
      rwr       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_payload.kind)
                  KIND_LEFT: begin
                     lwr = ({1'b0, req_payload.row_index} < lr) &&
                           ({1'b0, req_payload.col_index} < lc);
                  end
                  KIND_RIGHT: begin
                     rwr = ({1'b0, req_payload.row_index} < rr) &&
                           ({1'b0, req_payload.col_index} < rc);
                  end
                  KIND_COMPUTE: begin
                     if (dim_err) begin
                        state_in = ST_ERROR;
                     end else begin
                        i_in     = '0;
                        k_in     = '0;
                        state_in = ST_ISSUE;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_ISSUE: begin
            issue = 1'b1;
            if ({1'b0, k_ff} == 4'(lc - 4'd1)) begin
               k_in     = '0;
               cnt_in   = '0;
               state_in = ST_DRAIN;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (cnt_ff == DRAIN_W'(DRAIN_CYC - 1)) begin
               j_in     = '0;
               state_in = ST_EMIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               emit_ok = 1'b1;
               if ({1'b0, j_ff} == 4'(rc - 4'd1)) begin
                  if ({1'b0, i_ff} == 4'(lr - 4'd1)) begin
                     state_in = ST_IDLE;
                  end else begin
                     i_in     = i_ff + 1'b1;
                     state_in = ST_ISSUE;
                  end
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end
         end
         ST_ERROR: begin
            if (out_free) begin
               err_ld   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // left store with registered read into the chain head
   assign rd_addr = {i_ff, k_ff};

   always_ff @(posedge clock) begin
      if (lwr) begin
         left_mem[{req_payload.row_index, req_payload.col_index}] <= req_payload.element_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_vld_ff <= '0;
      end else if (lwr) begin
         left_vld_ff[{req_payload.row_index, req_payload.col_index}] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_c[0].vld <= 1'b0;
      end else begin
         tok_c[0].vld <= issue;
      end
      tok_c[0].first <= (k_ff == '0);
      tok_c[0].last  <= ({1'b0, k_ff} == 4'(lc - 4'd1));
      tok_c[0].k     <= k_ff;
      tok_c[0].a     <= left_vld_ff[rd_addr] ? left_mem[rd_addr] : '0;
   end

   // chain of column cells
   for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
      bwr_type bwr;
      assign bwr.en    = rwr && (req_payload.col_index == DIM_W'(g));
      assign bwr.row   = req_payload.row_index;
      assign bwr.value = req_payload.element_value;
      mme_cell u_cell (
         .clock (clock),
         .reset (reset),
         .tin   (tok_c[g]),
         .bwr   (bwr),
         .tout  (tok_c[g+1]),
         .res   (res_c[g])
      );
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_ok || err_ld) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (emit_ok) begin
         rsp_ff.out_row   <= i_ff;
         rsp_ff.out_col   <= j_ff;
         rsp_ff.out_value <= res_c[j_ff];
         rsp_ff.status    <= 1'b0;
         rsp_ff.last      <= ({1'b0, j_ff} == 4'(rc - 4'd1)) &&
                             ({1'b0, i_ff} == 4'(lr - 4'd1));
      end else if (err_ld) begin
         rsp_ff.out_row   <= '0;
         rsp_ff.out_col   <= '0;
         rsp_ff.out_value <= '0;
         rsp_ff.status    <= 1'b1;
         rsp_ff.last      <= 1'b1;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef NO_ASSERTIONS
   // an error result is always a lone, zero-valued, final result
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status) |-> (rsp_payload.last && rsp_payload.out_value == '0))
      else $error("error result not marked last or not zero");

   // the last cell passes on no token while results are read out
   a_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> !tok_c[MAX_DIM].vld)
      else $error("results read while chain still busy");

   // nothing issues into the chain outside the issue phase
   a_issue: assert property (@(posedge clock) disable iff (reset)
      tok_c[0].vld |-> $past(state_ff == ST_ISSUE))
      else $error("token issued outside issue phase");
`endif

endmodule

FILE: hw/rtl/mme_cell.sv
// One column cell of the multiply chain: holds a column of the right matrix,
// multiplies passing left elements and accumulates one product element. Uses mme_pkg.
module mme_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  mme_pkg::token_type              tin,
   input  mme_pkg::bwr_type                bwr,
   output mme_pkg::token_type              tout,
   output logic signed [mme_pkg::DATA_W-1:0] res
);
   import mme_pkg::*;

   logic signed [DATA_W-1:0] col_mem [MAX_DIM];
   logic [MAX_DIM-1:0]       col_vld_ff;
   token_type                tok_ff;
   logic signed [DATA_W-1:0] b_ff;
   logic signed [PROD_W-1:0] p_ff;
   logic                     p_vld_ff, p_first_ff, p_last_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic                     acc_last_ff;
   logic signed [DATA_W-1:0] res_ff;

   // store the right column element
   always_ff @(posedge clock) begin
      if (bwr.en) begin
         col_mem[bwr.row] <= bwr.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_vld_ff <= '0;
      end else if (bwr.en) begin
         col_vld_ff[bwr.row] <= 1'b1;
      end
   end

   // latch the token and read the matching right element
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.vld <= 1'b0;
      end else begin
         tok_ff.vld <= tin.vld;
      end
      tok_ff.first <= tin.first;
      tok_ff.last  <= tin.last;
      tok_ff.k     <= tin.k;
      tok_ff.a     <= tin.a;
      b_ff         <= col_vld_ff[tin.k] ? col_mem[tin.k] : '0;
   end

   // multiply
   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
      end else begin
         p_vld_ff <= tok_ff.vld;
      end
      p_first_ff <= tok_ff.first;
      p_last_ff  <= tok_ff.last;
      p_ff       <= tok_ff.a * b_ff;
   end

   // accumulate, restarting on the first term
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_last_ff <= 1'b0;
      end else begin
         acc_last_ff <= p_vld_ff & p_last_ff;
      end
      if (p_vld_ff) begin
         if (p_first_ff) begin
            acc_ff <= ACC_W'(p_ff);
         end else begin
            acc_ff <= acc_ff + ACC_W'(p_ff);
         end
      end
   end

   // round and hold the finished element
   always_ff @(posedge clock) begin
      if (acc_last_ff) begin
         res_ff <= sat_round(acc_ff);
      end
   end

   assign tout = tok_ff;
   assign res  = res_ff;

endmodule
